[design/tglc_pkg.sv]
// shared codes and constants for the two-group lru cache set
`timescale 1ns / 1ps
package tglc_pkg;

  localparam int TAG_BITS = 10;
  localparam int MODE_BITS = 3;
  localparam int PTIME_BITS = 8;
  localparam int SCOUNT_BITS = 9;
  localparam int SNUM_BITS = 8;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 9;
  // tag * set_count + set_number fits in this many bits
  localparam int PROD_BITS = TAG_BITS + SCOUNT_BITS + 1;

  localparam logic [MODE_BITS-1:0] MODE_READ = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_WRITE = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_TICK = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_FLUSH = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_PEEK = 3'd4;
  localparam logic [MODE_BITS-1:0] MODE_LOAD = 3'd5;

  localparam logic [CFG_IDX_BITS-1:0] CFG_PROMOTE_TIME = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SET_COUNT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SET_NUMBER = 2'd2;

  localparam logic [PTIME_BITS-1:0] PTIME_RESET = 8'd4;
  localparam logic [SCOUNT_BITS-1:0] SCOUNT_RESET = 9'd1;
  localparam logic [SNUM_BITS-1:0] SNUM_RESET = 8'd0;

endpackage

[design/tglc_addr_unit.sv]
// memory address unit: (tag * set_count + set_number) mod MemWords
`timescale 1ns / 1ps
module tglc_addr_unit #(
  parameter int MemWords = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [tglc_pkg::TAG_BITS-1:0]         tag,
  input  logic [tglc_pkg::SCOUNT_BITS-1:0]      set_count,
  input  logic [tglc_pkg::SNUM_BITS-1:0]        set_number,
  output logic                                  done,
  output logic [$clog2(MemWords)-1:0]           addr
);
  localparam int PW = tglc_pkg::PROD_BITS;
  localparam int AW = $clog2(MemWords);
  // floor(2^PW / MemWords); the quotient it gives is short by at most one
  localparam logic [PW-1:0] RECIP = PW'((longint'(1) << PW) / longint'(MemWords));
  localparam logic [PW-1:0] DIVISOR = PW'(MemWords);
  localparam logic [AW:0]   MOD_WIDE = (AW+1)'(MemWords);

  logic [2:0]      stg;
  logic [PW-1:0]   val;
  logic [PW-1:0]   quo;
  logic [AW:0]     rem;
  logic [2*PW-1:0] quo_prod;
  logic [2*PW-1:0] back_prod;

  assign quo_prod = (2*PW)'(val) * (2*PW)'(RECIP);
  assign back_prod = (2*PW)'(quo) * (2*PW)'(DIVISOR);
  assign done = stg[2];
  // remainder is below twice the modulus, one subtraction finishes it
  assign addr = (rem >= MOD_WIDE) ? AW'(rem - MOD_WIDE) : rem[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stg <= '0;
    end else begin
      stg <= {stg[1:0], start};
    end
    if (start) begin
      val <= PW'(tag) * PW'(set_count) + PW'(set_number);
    end
    if (stg[0]) begin
      quo <= quo_prod[2*PW-1:PW];
    end
    if (stg[1]) begin
      rem <= (AW+1)'(val - back_prod[PW-1:0]);
    end
  end
endmodule

[design/tglc_main_mem.sv]
// backing word memory with a clearing sweep after reset
`timescale 1ns / 1ps
module tglc_main_mem #(
  parameter int MemWords = 1024,
  parameter int WordBits = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          we,
  input  logic [$clog2(MemWords)-1:0]   waddr,
  input  logic [WordBits-1:0]           wdata,
  input  logic                          re,
  input  logic [$clog2(MemWords)-1:0]   raddr,
  output logic [WordBits-1:0]           rdata,
  output logic                          ready
);
  localparam int AW = $clog2(MemWords);

  logic [WordBits-1:0] mem [MemWords];
  logic [AW:0]         clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      ready <= 1'b0;
    end else if (!ready) begin
      if (clr_addr == (AW+1)'(MemWords - 1)) begin
        ready <= 1'b1;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ready) begin
      mem[clr_addr[AW-1:0]] <= '0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

[design/two_group_lru_cache_set.sv]
// two-group lru write-back cache set: controller, way state and block data
//
// usage: pulse start with mode, tag and data while busy is low; the item is
// taken at that edge and busy rises. when the item finishes, done is high for
// exactly one cycle with hit, word and wrote_back; the receiver must take it
// then, it cannot stall. configuration goes over cfg_valid/cfg_ready with
// cfg_index and cfg_data; cfg_ready is always high, so each transfer is taken
// at the edge where cfg_valid is high. write registers only while busy is low.
// steps: every memory address comes from the address unit. a write hit
// passes the lookup only, a read hit also reads the block, a miss writes
// back a dirty victim and then fills the way, peek and load each make one
// memory access, modes six and seven go straight to done, a tick visits each
// high way and a flush each way, writing back dirty ones. items are handled
// one at a time; the next one can be taken in the cycle after done.
// reset: rst is synchronous; all ways become invalid, clean and low, and the
// backing memory is zeroed by a sweep over all MemWords words, during which
// busy stays high.
`timescale 1ns / 1ps
module two_group_lru_cache_set #(
  parameter int Ways = 8,
  parameter int MemWords = 1024,
  parameter int WordBits = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [tglc_pkg::MODE_BITS-1:0]         mode,
  input  logic [tglc_pkg::TAG_BITS-1:0]          tag,
  input  logic [WordBits-1:0]                    data,
  output logic                                   done,
  output logic                                   hit,
  output logic [WordBits-1:0]                    word,
  output logic                                   wrote_back,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [tglc_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [tglc_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
  localparam int RW = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int CW = $clog2(Ways + 1);
  localparam int AW = $clog2(MemWords);
  localparam int TW = tglc_pkg::TAG_BITS;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LOOK   = 4'd1;
  localparam logic [3:0] S_HITRD  = 4'd2;
  localparam logic [3:0] S_WB     = 4'd3;
  localparam logic [3:0] S_FILL   = 4'd4;
  localparam logic [3:0] S_FILLRD = 4'd5;
  localparam logic [3:0] S_TICK   = 4'd6;
  localparam logic [3:0] S_FLUSH  = 4'd7;
  localparam logic [3:0] S_FLWAIT = 4'd8;
  localparam logic [3:0] S_PEEK   = 4'd9;
  localparam logic [3:0] S_PEEKRD = 4'd10;
  localparam logic [3:0] S_LOAD   = 4'd11;
  localparam logic [3:0] S_OUT    = 4'd12;

  logic [3:0] state;

  logic [tglc_pkg::PTIME_BITS-1:0]  promote_time;
  logic [tglc_pkg::SCOUNT_BITS-1:0] set_count;
  logic [tglc_pkg::SNUM_BITS-1:0]   set_number;

  logic [tglc_pkg::MODE_BITS-1:0] cur_mode;
  logic [TW-1:0]                  cur_tag;
  logic [WordBits-1:0]            cur_data;
  logic [RW-1:0]                  cur_way;
  logic [CW-1:0]                  idx;

  logic [TW-1:0]                   way_tag [Ways];
  logic [Ways-1:0]                 way_valid;
  logic [Ways-1:0]                 way_dirty;
  logic [tglc_pkg::PTIME_BITS-1:0] way_timer [Ways];
  logic [Ways-1:0]                 way_in_high;
  logic [RW-1:0]                   way_rank [Ways];

  // block data store, undefined until filled
  logic [WordBits-1:0] way_data [Ways];
  logic                wd_we;
  logic [RW-1:0]       wd_waddr;
  logic [WordBits-1:0] wd_wdata;
  logic                wd_re;
  logic [RW-1:0]       wd_raddr;
  logic [WordBits-1:0] wd_rdata;

  always_ff @(posedge clk) begin
    if (wd_we) begin
      way_data[wd_waddr] <= wd_wdata;
    end
    if (wd_re) begin
      wd_rdata <= way_data[wd_raddr];
    end
  end

  // address unit and backing memory
  logic          a_start;
  logic [TW-1:0] a_tag;
  logic          a_done;
  logic [AW-1:0] a_addr;
  logic          m_we;
  logic [WordBits-1:0] m_wdata;
  logic          m_re;
  logic [WordBits-1:0] m_rdata;
  logic          m_ready;

  tglc_addr_unit #(.MemWords(MemWords)) u_addr (
    .clk(clk), .rst(rst), .start(a_start), .tag(a_tag),
    .set_count(set_count), .set_number(set_number),
    .done(a_done), .addr(a_addr)
  );

  tglc_main_mem #(.MemWords(MemWords), .WordBits(WordBits)) u_mem (
    .clk(clk), .rst(rst), .we(m_we), .waddr(a_addr), .wdata(m_wdata),
    .re(m_re), .raddr(a_addr), .rdata(m_rdata), .ready(m_ready)
  );

  // lookup, victim choice and tick scan
  logic          hit_f;
  logic [RW-1:0] hit_w;
  logic [CW-1:0] nh;
  logic          vhi;
  logic [CW-1:0] want;
  logic [RW-1:0] vic_w;
  logic          tk_f;
  logic [RW-1:0] tk_w;

  always_comb begin
    hit_f = 1'b0;
    hit_w = '0;
    nh = '0;
    vic_w = '0;
    tk_f = 1'b0;
    tk_w = '0;
    for (int v = Ways - 1; v >= 0; v--) begin
      if (way_valid[v] && way_tag[v] == cur_tag) begin
        hit_f = 1'b1;
        hit_w = RW'(v);
      end
      if (way_in_high[v]) begin
        nh = nh + 1'b1;
      end
    end
    vhi = (nh == CW'(Ways));
    want = CW'(Ways - 1) - (vhi ? '0 : nh);
    for (int v = Ways - 1; v >= 0; v--) begin
      if (way_in_high[v] == vhi && CW'(way_rank[v]) == want) begin
        vic_w = RW'(v);
      end
      if (way_in_high[v] && CW'(way_rank[v]) == idx) begin
        tk_f = 1'b1;
        tk_w = RW'(v);
      end
    end
  end

  // move one way to the front of a group
  logic          tf_en;
  logic [RW-1:0] tf_way;
  logic          tf_hi;
  logic [RW-1:0] rank_next [Ways];
  logic          og;
  logic [RW-1:0] orank;

  always_comb begin
    og = way_in_high[tf_way];
    orank = way_rank[tf_way];
    for (int v = 0; v < Ways; v++) begin
      rank_next[v] = way_rank[v];
      if (RW'(v) == tf_way) begin
        rank_next[v] = '0;
      end else begin
        if (way_in_high[v] == og && way_rank[v] > orank) begin
          rank_next[v] = rank_next[v] - 1'b1;
        end
        if (way_in_high[v] == tf_hi) begin
          rank_next[v] = rank_next[v] + 1'b1;
        end
      end
    end
  end

  // controller strobes
  always_comb begin
    a_start = 1'b0;
    a_tag = cur_tag;
    m_we = 1'b0;
    m_wdata = wd_rdata;
    m_re = 1'b0;
    wd_we = 1'b0;
    wd_waddr = cur_way;
    wd_wdata = cur_data;
    wd_re = 1'b0;
    wd_raddr = cur_way;
    tf_en = 1'b0;
    tf_way = cur_way;
    tf_hi = 1'b0;
    case (state)
      S_IDLE: begin
        if (start && m_ready && (mode == tglc_pkg::MODE_PEEK ||
                                 mode == tglc_pkg::MODE_LOAD)) begin
          a_start = 1'b1;
          a_tag = tag;
        end
      end
      S_LOOK: begin
        if (hit_f) begin
          tf_en = 1'b1;
          tf_way = hit_w;
          tf_hi = 1'b1;
          wd_waddr = hit_w;
          wd_raddr = hit_w;
          wd_we = (cur_mode == tglc_pkg::MODE_WRITE);
          wd_re = (cur_mode != tglc_pkg::MODE_WRITE);
        end else if (way_valid[vic_w] && way_dirty[vic_w]) begin
          wd_raddr = vic_w;
          wd_re = 1'b1;
          a_start = 1'b1;
          a_tag = way_tag[vic_w];
        end else begin
          a_start = 1'b1;
        end
      end
      S_WB: begin
        if (a_done) begin
          m_we = 1'b1;
          a_start = 1'b1;
        end
      end
      S_FILL: begin
        m_re = a_done;
      end
      S_FILLRD: begin
        wd_we = 1'b1;
        wd_wdata = (cur_mode == tglc_pkg::MODE_WRITE) ? cur_data : m_rdata;
        tf_en = 1'b1;
      end
      S_TICK: begin
        tf_way = tk_w;
        tf_en = tk_f && (way_timer[tk_w] == '0);
      end
      S_FLUSH: begin
        if (idx != CW'(Ways) && way_valid[idx[RW-1:0]] && way_dirty[idx[RW-1:0]]) begin
          wd_raddr = idx[RW-1:0];
          wd_re = 1'b1;
          a_start = 1'b1;
          a_tag = way_tag[idx[RW-1:0]];
        end
      end
      S_FLWAIT: begin
        m_we = a_done;
      end
      S_PEEK: begin
        m_re = a_done;
      end
      S_LOAD: begin
        m_we = a_done;
        m_wdata = cur_data;
      end
      default: begin
      end
    endcase
  end

  assign busy = (state != S_IDLE) || !m_ready;
  assign done = (state == S_OUT);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      promote_time <= tglc_pkg::PTIME_RESET;
      set_count <= tglc_pkg::SCOUNT_RESET;
      set_number <= tglc_pkg::SNUM_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        tglc_pkg::CFG_PROMOTE_TIME: promote_time <= cfg_data[tglc_pkg::PTIME_BITS-1:0];
        tglc_pkg::CFG_SET_COUNT:    set_count <= cfg_data;
        tglc_pkg::CFG_SET_NUMBER:   set_number <= cfg_data[tglc_pkg::SNUM_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      way_valid <= '0;
      way_dirty <= '0;
      way_in_high <= '0;
      for (int v = 0; v < Ways; v++) begin
        way_tag[v] <= '0;
        way_timer[v] <= '0;
        way_rank[v] <= RW'(v);
      end
      hit <= 1'b0;
      word <= '0;
      wrote_back <= 1'b0;
    end else begin
      if (tf_en) begin
        for (int v = 0; v < Ways; v++) begin
          way_rank[v] <= rank_next[v];
        end
        way_in_high[tf_way] <= tf_hi;
      end
      case (state)
        S_IDLE: begin
          if (start && m_ready) begin
            cur_mode <= mode;
            cur_tag <= tag;
            cur_data <= data;
            idx <= '0;
            hit <= 1'b0;
            word <= '0;
            wrote_back <= 1'b0;
            case (mode)
              tglc_pkg::MODE_READ,
              tglc_pkg::MODE_WRITE: state <= S_LOOK;
              tglc_pkg::MODE_TICK:  state <= S_TICK;
              tglc_pkg::MODE_FLUSH: state <= S_FLUSH;
              tglc_pkg::MODE_PEEK:  state <= S_PEEK;
              tglc_pkg::MODE_LOAD:  state <= S_LOAD;
              default:              state <= S_OUT;
            endcase
          end
        end
        S_LOOK: begin
          if (hit_f) begin
            hit <= 1'b1;
            way_timer[hit_w] <= promote_time;
            if (cur_mode == tglc_pkg::MODE_WRITE) begin
              way_dirty[hit_w] <= 1'b1;
              word <= cur_data;
              state <= S_OUT;
            end else begin
              cur_way <= hit_w;
              state <= S_HITRD;
            end
          end else begin
            cur_way <= vic_w;
            state <= (way_valid[vic_w] && way_dirty[vic_w]) ? S_WB : S_FILL;
          end
        end
        S_HITRD: begin
          word <= wd_rdata;
          state <= S_OUT;
        end
        S_WB: begin
          if (a_done) begin
            wrote_back <= 1'b1;
            state <= S_FILL;
          end
        end
        S_FILL: begin
          if (a_done) begin
            state <= S_FILLRD;
          end
        end
        S_FILLRD: begin
          way_tag[cur_way] <= cur_tag;
          way_valid[cur_way] <= 1'b1;
          way_dirty[cur_way] <= (cur_mode == tglc_pkg::MODE_WRITE);
          way_timer[cur_way] <= '0;
          word <= (cur_mode == tglc_pkg::MODE_WRITE) ? cur_data : m_rdata;
          state <= S_OUT;
        end
        S_TICK: begin
          // idx counts high ways kept so far; the next one sits at that rank
          if (!tk_f) begin
            state <= S_OUT;
          end else if (way_timer[tk_w] != '0) begin
            way_timer[tk_w] <= way_timer[tk_w] - 1'b1;
            idx <= idx + 1'b1;
          end
        end
        S_FLUSH: begin
          if (idx == CW'(Ways)) begin
            state <= S_OUT;
          end else if (way_valid[idx[RW-1:0]] && way_dirty[idx[RW-1:0]]) begin
            state <= S_FLWAIT;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_FLWAIT: begin
          if (a_done) begin
            wrote_back <= 1'b1;
            idx <= idx + 1'b1;
            state <= S_FLUSH;
          end
        end
        S_PEEK: begin
          if (a_done) begin
            state <= S_PEEKRD;
          end
        end
        S_PEEKRD: begin
          word <= m_rdata;
          state <= S_OUT;
        end
        S_LOAD: begin
          if (a_done) begin
            word <= cur_data;
            state <= S_OUT;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
